// File: rtl/sigtran_tlv_message_parser_macros.svh
// assertion macros for the tlv message parser
`ifndef SIGTRAN_TLV_MESSAGE_PARSER_MACROS_SVH
`define SIGTRAN_TLV_MESSAGE_PARSER_MACROS_SVH
`ifndef SYNTHESIS
`define STMP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("stmp check failed");
`define STMP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("stmp check failed");
`else
`define STMP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define STMP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/stmp_pkg.sv
// shared types, codes and helper functions of the tlv message parser
package stmp_pkg;

	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_PHDR   = 3'd1;
	localparam logic [2:0] PH_VALUE  = 3'd2;
	localparam logic [2:0] PH_PAD    = 3'd3;
	localparam logic [2:0] PH_SKIP   = 3'd4;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_PARAM  = 2'd1;
	localparam logic [1:0] KIND_BAD    = 2'd2;
	localparam logic [1:0] KIND_END    = 2'd3;

	localparam logic [15:0] HDR_LEN  = 16'd8;
	localparam logic [15:0] PHDR_LEN = 16'd4;

	localparam int OUT_TDATA_W = 128;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] hdr;
		logic        with_param;
		logic [15:0] tag;
		logic [15:0] len;
		logic [31:0] value;
		logic        eom;
	} rec_t;

	function automatic logic [1:0] pad_of(input logic [15:0] len);
		pad_of = 2'd0 - len[1:0];
	endfunction

	function automatic logic [3:0] kind_of(input logic [15:0] tag);
		logic [3:0] k;
		unique case (tag)
			16'd1:   k = 4'd0;
			16'd2:   k = 4'd1;
			16'd3:   k = 4'd2;
			16'd4:   k = 4'd3;
			16'd7:   k = 4'd4;
			16'd9:   k = 4'd5;
			16'd10:  k = 4'd6;
			16'd12:  k = 4'd7;
			16'd13:  k = 4'd8;
			default: k = 4'd9;
		endcase
		kind_of = k;
	endfunction

	function automatic logic known_pair(input logic [7:0] cls, input logic [7:0] typ);
		logic [15:0] key;
		key = {cls, typ};
		known_pair = (key == 16'h0000) || (key == 16'hFF01) ||
			((key >= 16'h0301) && (key <= 16'h0306));
	endfunction

endpackage

// File: rtl/stmp_front.sv
// front end: byte acceptance, parse state and record building
`include "sigtran_tlv_message_parser_macros.svh"
module stmp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,
	input  logic              s_tlast,
	input  logic              q_ready,
	output logic              push,
	output stmp_pkg::rec_t    rec
);

	localparam logic [1:0] ST_NONE = 2'd0;
	localparam logic [1:0] ST_DONE = 2'd1;
	localparam logic [1:0] ST_BAD  = 2'd2;

	logic [2:0]  phase_q, phase_n;
	logic [15:0] cnt_q, cnt_n, cnt_inc;
	logic [63:0] hdr_q, hdr_n;
	logic [15:0] tag_q, tag_n;
	logic [15:0] len_q, len_n;
	logic [31:0] val_q, val_n;
	logic [1:0]  status;
	logic        emit, wp, reom, acc, eom, param_ph;
	logic [1:0]  rkind;
	logic [7:0]  b;

	assign s_tready = q_ready;
	assign acc      = s_tvalid & q_ready;
	assign b        = s_tdata;
	assign eom      = s_tlast;
	assign cnt_inc  = cnt_q + 16'd1;

	always_comb begin
		phase_n  = phase_q;
		cnt_n    = cnt_q;
		hdr_n    = hdr_q;
		tag_n    = tag_q;
		len_n    = len_q;
		val_n    = val_q;
		status   = ST_NONE;
		emit     = 1'b0;
		wp       = 1'b0;
		reom     = 1'b0;
		rkind    = stmp_pkg::KIND_BAD;
		param_ph = 1'b0;
		unique case (phase_q)
			stmp_pkg::PH_PHDR: begin
				param_ph = 1'b1;
				if (cnt_q == 16'd0) begin
					tag_n = '0;
					len_n = '0;
					val_n = '0;
				end
				unique case (cnt_q[1:0])
					2'd0: tag_n[15:8] = tag_n[15:8] | b;
					2'd1: tag_n[7:0]  = tag_n[7:0] | b;
					2'd2: len_n[15:8] = len_n[15:8] | b;
					default: len_n[7:0] = len_n[7:0] | b;
				endcase
				cnt_n = cnt_inc;
				if (cnt_inc >= stmp_pkg::PHDR_LEN) begin
					if (len_n < stmp_pkg::PHDR_LEN) begin
						status = ST_BAD;
					end else if (len_n == stmp_pkg::PHDR_LEN) begin
						status = ST_DONE;
					end else begin
						phase_n = stmp_pkg::PH_VALUE;
						cnt_n   = '0;
					end
				end
			end
			stmp_pkg::PH_VALUE: begin
				param_ph = 1'b1;
				if (cnt_q < 16'd4) begin
					unique case (cnt_q[1:0])
						2'd0: val_n[31:24] = val_n[31:24] | b;
						2'd1: val_n[23:16] = val_n[23:16] | b;
						2'd2: val_n[15:8]  = val_n[15:8] | b;
						default: val_n[7:0] = val_n[7:0] | b;
					endcase
				end
				cnt_n = cnt_inc;
				if ({1'b0, cnt_inc} + 17'd4 >= {1'b0, len_q}) begin
					if (stmp_pkg::pad_of(len_q) == 2'd0) begin
						status = ST_DONE;
					end else begin
						phase_n = stmp_pkg::PH_PAD;
						cnt_n   = '0;
					end
				end
			end
			stmp_pkg::PH_PAD: begin
				param_ph = 1'b1;
				cnt_n    = cnt_inc;
				if (cnt_inc >= {14'd0, stmp_pkg::pad_of(len_q)})
					status = ST_DONE;
			end
			stmp_pkg::PH_SKIP: begin
				if (eom) begin
					emit    = 1'b1;
					rkind   = stmp_pkg::KIND_END;
					wp      = 1'b1;
					reom    = 1'b1;
					phase_n = stmp_pkg::PH_HEADER;
					cnt_n   = '0;
				end
			end
			default: begin
				if (cnt_q == 16'd0)
					hdr_n = '0;
				for (int i = 0; i < 8; i++) begin
					if (cnt_q[2:0] == 3'(i))
						hdr_n[63 - 8 * i -: 8] = hdr_n[63 - 8 * i -: 8] | b;
				end
				cnt_n = cnt_inc;
				if (cnt_inc >= stmp_pkg::HDR_LEN) begin
					emit    = 1'b1;
					rkind   = stmp_pkg::KIND_HEADER;
					reom    = eom;
					phase_n = eom ? stmp_pkg::PH_HEADER : stmp_pkg::PH_PHDR;
					cnt_n   = '0;
				end else if (eom) begin
					emit    = 1'b1;
					rkind   = stmp_pkg::KIND_BAD;
					reom    = 1'b1;
					phase_n = stmp_pkg::PH_HEADER;
					cnt_n   = '0;
				end
			end
		endcase
		if (param_ph && (status != ST_NONE || eom)) begin
			priority if (status == ST_DONE) begin
				emit    = 1'b1;
				rkind   = stmp_pkg::KIND_PARAM;
				wp      = 1'b1;
				reom    = eom;
				phase_n = eom ? stmp_pkg::PH_HEADER : stmp_pkg::PH_PHDR;
				cnt_n   = '0;
			end else if (status == ST_BAD) begin
				emit    = 1'b1;
				rkind   = stmp_pkg::KIND_BAD;
				wp      = 1'b1;
				reom    = eom;
				phase_n = eom ? stmp_pkg::PH_HEADER : stmp_pkg::PH_SKIP;
				cnt_n   = '0;
			end else begin
				emit    = 1'b1;
				rkind   = stmp_pkg::KIND_BAD;
				wp      = 1'b1;
				reom    = 1'b1;
				phase_n = stmp_pkg::PH_HEADER;
				cnt_n   = '0;
			end
		end
	end

	assign push           = acc & emit;
	assign rec.kind       = rkind;
	assign rec.hdr        = hdr_n;
	assign rec.with_param = wp;
	assign rec.tag        = tag_n;
	assign rec.len        = len_n;
	assign rec.value      = val_n;
	assign rec.eom        = reom;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= stmp_pkg::PH_HEADER;
			cnt_q   <= '0;
			hdr_q   <= '0;
			tag_q   <= '0;
			len_q   <= '0;
			val_q   <= '0;
		end else if (acc) begin
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			hdr_q   <= hdr_n;
			tag_q   <= tag_n;
			len_q   <= len_n;
			val_q   <= val_n;
		end
	end

	`STMP_ASSERT_NXT(a_eom_restart, clk, arst_n, acc && s_tlast, phase_q == stmp_pkg::PH_HEADER && cnt_q == 16'd0)
	`STMP_ASSERT_IMP(a_skip_quiet, clk, arst_n, acc && phase_q == stmp_pkg::PH_SKIP && !s_tlast, !push)

endmodule

// File: rtl/stmp_queue.sv
// two-entry record queue between front and back
`include "sigtran_tlv_message_parser_macros.svh"
module stmp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  stmp_pkg::rec_t din,
	output logic           ready,
	input  logic           pop,
	output stmp_pkg::rec_t dout,
	output logic           not_empty
);

	stmp_pkg::rec_t mem_q [2];
	logic           wr_q, rd_q;
	logic [1:0]     cnt_q;

	assign ready     = (cnt_q != 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign dout      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`STMP_ASSERT_IMP(a_no_overflow, clk, arst_n, push, cnt_q != 2'd2)
	`STMP_ASSERT_IMP(a_no_underflow, clk, arst_n, pop, cnt_q != 2'd0)

endmodule

// File: rtl/stmp_back.sv
// back end: record formatting and output register
`include "sigtran_tlv_message_parser_macros.svh"
module stmp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           not_empty,
	input  stmp_pkg::rec_t head,
	output logic           pop,
	output logic           m_tvalid,
	input  logic           m_tready,
	// version, msg_class, msg_type, msg_length, class_type_known, param_tag,
	// param_length, param_kind, param_value, padding_bytes, zero fill
	output logic [stmp_pkg::OUT_TDATA_W-1:0] m_tdata,
	// record_kind
	output logic [1:0]     m_tuser,
	output logic           m_tlast
);

	logic        vld_q, load;
	logic [1:0]  kind_q, pad_q;
	logic [7:0]  ver_q, cls_q, typ_q;
	logic [31:0] mlen_q, val_q;
	logic        known_q, eom_q;
	logic [15:0] tag_q, plen_q;
	logic [3:0]  pkind_q;

	assign load = not_empty && (!vld_q || m_tready);
	assign pop  = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= 1'b0;
		else if (load)
			vld_q <= 1'b1;
		else if (m_tready)
			vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q  <= head.kind;
			ver_q   <= head.hdr[63:56];
			cls_q   <= head.hdr[47:40];
			typ_q   <= head.hdr[39:32];
			mlen_q  <= head.hdr[31:0];
			known_q <= stmp_pkg::known_pair(head.hdr[47:40], head.hdr[39:32]);
			tag_q   <= head.with_param ? head.tag : 16'd0;
			plen_q  <= head.with_param ? head.len : 16'd0;
			pkind_q <= head.with_param ? stmp_pkg::kind_of(head.tag) : 4'd0;
			val_q   <= head.with_param ? head.value : 32'd0;
			pad_q   <= head.with_param ? stmp_pkg::pad_of(head.len) : 2'd0;
			eom_q   <= head.eom;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = eom_q;
	assign m_tdata  = {1'b0, pad_q, val_q, pkind_q, plen_q, tag_q, known_q,
		mlen_q, typ_q, cls_q, ver_q};

	`STMP_ASSERT_IMP(a_hdr_no_param, clk, arst_n, vld_q && kind_q == stmp_pkg::KIND_HEADER, tag_q == 16'd0 && pkind_q == 4'd0 && pad_q == 2'd0)

endmodule

// File: rtl/sigtran_tlv_message_parser.sv
// top level of the tlv message parser: front end, record queue, back end
// a finished record passes the record queue, then the output register, to m_tvalid
// throughput: one byte per cycle while the queue has room; at most one record per byte, set by the single state update
// the two-entry record queue and the output register let input and output stall apart
// reset: arst_n clears parse state, queue and output valid at once; no clearing pass
module sigtran_tlv_message_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// data_byte
	input  logic [7:0]  s_tdata,
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// version, msg_class, msg_type, msg_length, class_type_known, param_tag,
	// param_length, param_kind, param_value, padding_bytes, zero fill
	output logic [stmp_pkg::OUT_TDATA_W-1:0] m_tdata,
	// record_kind
	output logic [1:0]  m_tuser,
	output logic        m_tlast
);

	stmp_pkg::rec_t rec, head;
	logic           push, q_ready, pop, not_empty;

	stmp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_ready  (q_ready),
		.push     (push),
		.rec      (rec)
	);

	stmp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.din       (rec),
		.ready     (q_ready),
		.pop       (pop),
		.dout      (head),
		.not_empty (not_empty)
	);

	stmp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.head      (head),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
